FILE: rtl/swpd_pkg.sv
// Shared constants for the sliding-window peak detector.
package swpd_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int PEAK_W         = 2;
    localparam int THR_W          = 8;
    localparam int DEF_RING_DEPTH = 16;

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0]   THR_RESET     = 8'd48;

    // Result codes
    localparam logic [PEAK_W-1:0] PEAK_NONE = 2'b00;
    localparam logic [PEAK_W-1:0] PEAK_POS  = 2'b01;
    localparam logic [PEAK_W-1:0] PEAK_NEG  = 2'b11;

endpackage

FILE: rtl/swpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/sliding_window_peak_detector_core.sv
// Sliding-window z-score peak detector, top level.
// Usage:
//   Input channel (in_valid / in_stall / sample): one signed 16-bit sample
//   per item. Output channel (out_valid / out_stall / peak_dir): one result
//   item per input item, +1 peak above the window mean, -1 below, 0 none.
//   APB port: register 0 (byte address 0) is threshold, unsigned Q4.4,
//   reset value 3.0. Write it only while the block is idle.
// Sequence:
//   While the ring of the last RING_DEPTH samples is filling, an item goes
//   from acceptance straight to the output state, and its result 0 is
//   loaded into the output register once that is free. Once full, an item
//   runs a variance pass: it reads every stored sample through the single
//   read port of the ring RAM, one per cycle, through a three-stage
//   deviation / square / accumulate pipe and a drain check, then comes a
//   multiply, a compare-and-write-back, an output and an accept step.
//   One item is in flight at a time; in_stall is high while it is worked on.
// Reset clears fill count, write slot and running sum and sets threshold to
// 3.0; the ring RAM is never cleared since no entry is read before written.
// A stalled output holds its item; the next item is still accepted and runs
// up to its output cycle, then waits.
module sliding_window_peak_detector_core #(
    parameter int RING_DEPTH = swpd_pkg::DEF_RING_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swpd_pkg::PADDR_W-1:0]  paddr,
    input  logic [swpd_pkg::PDATA_W-1:0]  pwdata,
    output logic [swpd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // sample input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [swpd_pkg::SAMPLE_W-1:0] sample,
    // result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [swpd_pkg::PEAK_W-1:0]   peak_dir
);

    import swpd_pkg::*;

    // Widths follow from the window size
    localparam int LOG_N  = $clog2(RING_DEPTH);
    localparam int AW     = (RING_DEPTH > 1) ? LOG_N : 1;
    localparam int CNT_W  = AW + 1;
    localparam int SUM_W  = SAMPLE_W + LOG_N;     // running sum
    localparam int MAG_W  = SAMPLE_W + LOG_N;     // |N*h - S|
    localparam int DEV_W  = MAG_W + 1;            // signed N*h - S
    localparam int SQ_W   = 2 * MAG_W;            // one squared deviation
    localparam int ACC_W  = SQ_W + LOG_N;         // variance sum
    localparam int CMP_W  = ACC_W + 2 * THR_W;    // both sides of the test
    localparam int TSQ_W  = 2 * THR_W;

    localparam logic [CNT_W-1:0]        N_CNT  = CNT_W'(RING_DEPTH);
    localparam logic [AW-1:0]           LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic signed [DEV_W-1:0] N_S    = DEV_W'(RING_DEPTH);
    localparam logic [LOG_N:0]          N_U    = (LOG_N + 1)'(RING_DEPTH);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_PUT  = 3'd4;

    logic [2:0]              state_reg;
    logic [THR_W-1:0]        threshold_reg;
    logic [CNT_W-1:0]        fill_reg;
    logic [AW-1:0]           slot_reg;
    logic signed [SUM_W-1:0] sum_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [DEV_W-1:0]    dev_reg;
    logic [TSQ_W-1:0]           tsq_reg;
    logic [SQ_W-1:0]            d2_reg;

    // Variance pipe
    logic [CNT_W-1:0]           rd_cnt_reg;
    logic                       v1_reg;
    logic [AW-1:0]              idx1_reg;
    logic                       v2_reg;
    logic signed [DEV_W-1:0]    e_reg;
    logic                       v3_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic signed [SAMPLE_W-1:0] old_reg;

    logic [CMP_W-1:0]           lhs_reg;
    logic [CMP_W-1:0]           rhs_reg;
    logic [PEAK_W-1:0]          peak_reg;

    logic                       out_valid_reg;
    logic [PEAK_W-1:0]          out_peak_reg;

    // RAM port signals
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic [SAMPLE_W-1:0]        ram_wr_data;
    logic                       ram_rd_en;
    logic [SAMPLE_W-1:0]        ram_rd_data;

    logic                       in_accept;
    logic                       filling;
    logic                       out_free;
    logic                       cfg_write;

    logic signed [DEV_W-1:0]    x_ext;
    logic signed [DEV_W-1:0]    h_ext;
    logic signed [DEV_W-1:0]    s_ext;
    logic signed [DEV_W-1:0]    dev_c;
    logic signed [DEV_W-1:0]    e_c;
    logic signed [2*DEV_W-1:0]  sq_full;
    logic signed [2*DEV_W-1:0]  d2_full;
    logic [CMP_W-1:0]           lhs_c;
    logic [CMP_W-1:0]           rhs_c;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign filling   = (fill_reg < N_CNT);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign peak_dir  = out_peak_reg;

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[PADDR_W-1:2] == REG_THRESHOLD);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_THRESHOLD)
                       ? PDATA_W'(threshold_reg) : '0;

    // Deviation arithmetic in DEV_W signed, plus the squares and both sides of the test
    always_comb
    begin
        x_ext   = DEV_W'(sample);
        h_ext   = DEV_W'($signed(ram_rd_data));
        s_ext   = DEV_W'(sum_reg);
        dev_c   = N_S * x_ext - s_ext;
        e_c     = N_S * h_ext - s_ext;
        sq_full = e_reg * e_reg;
        d2_full = dev_reg * dev_reg;
        lhs_c   = {(CMP_W - 8)'(d2_reg * N_U), 8'h00};
        rhs_c   = acc_reg * tsq_reg;
    end

    // RAM: fill writes at fill slot, steady state writes the oldest slot
    assign ram_wr_en   = (in_accept && filling) || (state_reg == ST_CMP);
    assign ram_wr_addr = (state_reg == ST_CMP) ? slot_reg : fill_reg[AW-1:0];
    assign ram_wr_data = (state_reg == ST_CMP) ? x_reg : sample;
    assign ram_rd_en   = (state_reg == ST_SCAN) && (rd_cnt_reg < N_CNT);

    swpd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            threshold_reg <= THR_RESET;
            fill_reg      <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            rd_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                threshold_reg <= pwdata[THR_W-1:0];
            end

            // new result loads the output register, else a taken one leaves
            if ((state_reg == ST_PUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // pipe valids
            v1_reg <= ram_rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (filling)
                        begin
                            fill_reg  <= fill_reg + 1'b1;
                            sum_reg   <= sum_reg + SUM_W'(sample);
                            state_reg <= ST_PUT;
                        end
                        else
                        begin
                            rd_cnt_reg <= '0;
                            state_reg  <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (ram_rd_en)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    else if (!v1_reg && !v2_reg && !v3_reg)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    // replace the oldest sample
                    sum_reg   <= sum_reg - SUM_W'(old_reg) + SUM_W'(x_reg);
                    slot_reg  <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    state_reg <= ST_PUT;
                end
                ST_PUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg    <= sample;
            dev_reg  <= dev_c;
            tsq_reg  <= threshold_reg * threshold_reg;
            acc_reg  <= '0;
            peak_reg <= PEAK_NONE;
        end

        idx1_reg <= rd_cnt_reg[AW-1:0];
        if (v1_reg)
        begin
            e_reg <= e_c;
            if (idx1_reg == slot_reg)
            begin
                old_reg <= $signed(ram_rd_data);
            end
        end
        if (v2_reg)
        begin
            sq_reg <= sq_full[SQ_W-1:0];
        end
        if (v3_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(sq_reg);
        end

        if (state_reg == ST_SCAN)
        begin
            d2_reg <= d2_full[SQ_W-1:0];
        end

        if (state_reg == ST_MUL)
        begin
            lhs_reg <= lhs_c;
            rhs_reg <= rhs_c;
        end

        if (state_reg == ST_CMP)
        begin
            if (lhs_reg > rhs_reg)
            begin
                peak_reg <= (dev_reg > 0) ? PEAK_POS : PEAK_NEG;
            end
            else
            begin
                peak_reg <= PEAK_NONE;
            end
        end

        if ((state_reg == ST_PUT) && out_free)
        begin
            out_peak_reg <= peak_reg;
        end
    end

endmodule
